// ===== rtl/stt_pkg.sv =====
// shared types, constants and byte-class helpers of the source text tokenizer
`timescale 1ns / 1ps

package stt_pkg;

   // width of a token offset, the position counter has one more bit; offsets saturate at 2**POS_BITS - 1
   localparam int POS_BITS = 16;
   localparam int POS_W = POS_BITS + 1;
   localparam int FIELD_BITS = 16;
   // compare width wide enough for both the position range and the field range
   localparam int CMP_W = (POS_W > FIELD_BITS + 1) ? POS_W : FIELD_BITS + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_DOT = 8'h2e;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;

   typedef enum logic [1:0] {
      CLASS_STRING = 2'd0,
      CLASS_IDENT  = 2'd1,
      CLASS_NUMBER = 2'd2,
      CLASS_PUNCT  = 2'd3
   } token_class_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_STRING = 4'b0010,
      MODE_IDENT  = 4'b0100,
      MODE_NUMBER = 4'b1000
   } scan_mode_type;

   // token as range [start, stop), stop already clamped to 2**POS_BITS
   typedef struct packed {
      logic [POS_BITS-1:0] start;
      logic [POS_W-1:0]    stop;
      token_class_type     cls;
      logic                ovf;
      logic                last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
   endfunction

   function automatic logic is_ident_head(input logic [7:0] b);
      return is_alpha(b) || (b == CHAR_UNDERSCORE);
   endfunction

   function automatic logic is_ident_tail(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || (b == CHAR_UNDERSCORE);
   endfunction

endpackage

// ===== rtl/stt_channels.sv =====
// handshake channel interfaces for text bytes in and token beats out
`timescale 1ns / 1ps

interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source(output valid, text_byte, end_of_text, input ready);
   modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [stt_pkg::FIELD_BITS-1:0]    token_start;
   logic [stt_pkg::FIELD_BITS-1:0]    token_length;
   logic [1:0]                        token_class;
   logic                              last_of_run;
   logic                              range_overflow;
   modport source(output valid, token_start, token_length, token_class, last_of_run,
                  range_overflow, input ready);
   modport sink(input valid, token_start, token_length, token_class, last_of_run,
                range_overflow, output ready);
endinterface

// ===== rtl/stt_front.sv =====
// scanner: classifies each byte, tracks the open token and emits token ranges
`timescale 1ns / 1ps

module stt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        text_byte,
   input  logic              end_of_text,
   output stt_pkg::push_type push
);

   stt_pkg::scan_mode_type          mode_ff, mode_in;
   logic                            single_ff, single_in;
   logic                            esc_ff, esc_in;
   logic [stt_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [stt_pkg::POS_BITS-1:0]    start_ff, start_in;
   logic                            ovf_seen_ff, ovf_seen_in;

   logic                            ovf_now;
   logic [stt_pkg::POS_BITS-1:0]    here;
   logic [stt_pkg::POS_W-1:0]       pos_next;
   logic [7:0]                      quote;
   logic                            handled;
   logic                            emit_a, emit_b, emit_c;
   stt_pkg::token_type              tok_a, tok_b, tok_c, tok_second;
   stt_pkg::scan_mode_type          mode_mid;
   logic                            single_mid, esc_mid;
   logic [stt_pkg::POS_BITS-1:0]    start_mid;

   always_comb begin
      ovf_now  = ovf_seen_ff | pos_ff[stt_pkg::POS_BITS];
      here     = pos_ff[stt_pkg::POS_BITS] ? '1 : pos_ff[stt_pkg::POS_BITS-1:0];
      // saturated position also serves as the clamped end of a token ending here
      pos_next = pos_ff[stt_pkg::POS_BITS] ? pos_ff : pos_ff + stt_pkg::POS_W'(1);
      quote    = single_ff ? stt_pkg::CHAR_SQUOTE : stt_pkg::CHAR_DQUOTE;

      mode_mid   = mode_ff;
      single_mid = single_ff;
      esc_mid    = esc_ff;
      start_mid  = start_ff;
      handled    = 1'b0;
      emit_a     = 1'b0;
      emit_b     = 1'b0;

      tok_a.start = start_ff;
      tok_a.stop  = pos_ff;
      tok_a.cls   = stt_pkg::CLASS_STRING;
      tok_a.ovf   = ovf_now;
      tok_a.last  = 1'b0;

      unique case (mode_ff)
         stt_pkg::MODE_STRING: begin
            handled = 1'b1;
            if (esc_ff) begin
               esc_mid = 1'b0;
            end else if (text_byte == quote) begin
               emit_a     = 1'b1;
               tok_a.stop = pos_next;
               mode_mid   = stt_pkg::MODE_IDLE;
            end else if (text_byte == stt_pkg::CHAR_BACKSLASH) begin
               esc_mid = 1'b1;
            end
         end
         stt_pkg::MODE_IDENT: begin
            tok_a.cls = stt_pkg::CLASS_IDENT;
            if (stt_pkg::is_ident_tail(text_byte)) begin
               handled = 1'b1;
            end else begin
               emit_a   = 1'b1;
               mode_mid = stt_pkg::MODE_IDLE;
            end
         end
         stt_pkg::MODE_NUMBER: begin
            tok_a.cls = stt_pkg::CLASS_NUMBER;
            if (stt_pkg::is_digit(text_byte) || (text_byte == stt_pkg::CHAR_DOT)) begin
               handled = 1'b1;
            end else begin
               emit_a   = 1'b1;
               mode_mid = stt_pkg::MODE_IDLE;
            end
         end
         default: begin
         end
      endcase

      if (!handled) begin
         priority if (stt_pkg::is_space(text_byte)) begin
         end else if ((text_byte == stt_pkg::CHAR_DQUOTE) ||
                      (text_byte == stt_pkg::CHAR_SQUOTE)) begin
            mode_mid   = stt_pkg::MODE_STRING;
            single_mid = (text_byte == stt_pkg::CHAR_SQUOTE);
            esc_mid    = 1'b0;
            start_mid  = here;
         end else if (stt_pkg::is_ident_head(text_byte)) begin
            mode_mid  = stt_pkg::MODE_IDENT;
            start_mid = here;
         end else if (stt_pkg::is_digit(text_byte)) begin
            mode_mid  = stt_pkg::MODE_NUMBER;
            start_mid = here;
         end else begin
            emit_b = 1'b1;
         end
      end

      tok_b.start = here;
      tok_b.stop  = pos_next;
      tok_b.cls   = stt_pkg::CLASS_PUNCT;
      tok_b.ovf   = ovf_now;
      tok_b.last  = 1'b1;

      // end of text flushes whatever token is still open
      emit_c      = end_of_text && (mode_mid != stt_pkg::MODE_IDLE);
      tok_c.start = start_mid;
      tok_c.stop  = pos_next;
      tok_c.ovf   = ovf_now;
      tok_c.last  = 1'b1;
      unique case (mode_mid)
         stt_pkg::MODE_STRING: tok_c.cls = stt_pkg::CLASS_STRING;
         stt_pkg::MODE_IDENT:  tok_c.cls = stt_pkg::CLASS_IDENT;
         default:              tok_c.cls = stt_pkg::CLASS_NUMBER;
      endcase

      // punctuation leaves no open token, so at most one of b and c fires
      tok_second = emit_b ? tok_b : tok_c;

      push.count  = 2'd0;
      push.first  = tok_a;
      push.second = tok_second;
      if (accept) begin
         priority if (emit_a && (emit_b || emit_c)) begin
            push.count = 2'd2;
         end else if (emit_a) begin
            push.count      = 2'd1;
            push.first.last = 1'b1;
         end else if (emit_b || emit_c) begin
            push.count = 2'd1;
            push.first = tok_second;
         end else begin
            push.count = 2'd0;
         end
      end

      if (end_of_text) begin
         mode_in     = stt_pkg::MODE_IDLE;
         single_in   = 1'b0;
         esc_in      = 1'b0;
         pos_in      = '0;
         start_in    = '0;
         ovf_seen_in = 1'b0;
      end else begin
         mode_in     = mode_mid;
         single_in   = single_mid;
         esc_in      = esc_mid;
         pos_in      = pos_next;
         start_in    = start_mid;
         ovf_seen_in = ovf_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= stt_pkg::MODE_IDLE;
         single_ff   <= 1'b0;
         esc_ff      <= 1'b0;
         pos_ff      <= '0;
         start_ff    <= '0;
         ovf_seen_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         single_ff   <= single_in;
         esc_ff      <= esc_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         ovf_seen_ff <= ovf_seen_in;
      end
   end

endmodule

// ===== rtl/stt_queue.sv =====
// token queue between scanner and output stage, takes up to two tokens a cycle
`timescale 1ns / 1ps

module stt_queue (
   input  logic               clock,
   input  logic               reset,
   input  stt_pkg::push_type  push,
   output logic               has_room,
   input  logic               pop,
   output logic               head_valid,
   output stt_pkg::token_type head
);

   stt_pkg::token_type               slot_ff [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [stt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic [stt_pkg::QPTR_W-1:0]       wr_ptr_plus;

   assign has_room    = count_ff <= stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH - 2);
   assign head_valid  = count_ff != '0;
   assign head        = slot_ff[rd_ptr_ff];
   assign wr_ptr_plus = wr_ptr_ff + stt_pkg::QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + stt_pkg::QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + stt_pkg::QPTR_W'(pop);
      count_in  = count_ff + stt_pkg::QCNT_W'(push.count) - stt_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_plus] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/stt_back.sv =====
// output stage: turns a token range into saturated start and length beats
`timescale 1ns / 1ps

module stt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  stt_pkg::token_type head,
   output logic               pop,
   stt_rsp_if.source          rsp_chan
);

   localparam logic [stt_pkg::CMP_W-1:0] POS_MAX_W =
      {{(stt_pkg::CMP_W - stt_pkg::POS_BITS){1'b0}}, {stt_pkg::POS_BITS{1'b1}}};
   localparam logic [stt_pkg::CMP_W-1:0] FIELD_MAX_W =
      {{(stt_pkg::CMP_W - stt_pkg::FIELD_BITS){1'b0}}, {stt_pkg::FIELD_BITS{1'b1}}};

   logic                              valid_ff, valid_in;
   logic [stt_pkg::FIELD_BITS-1:0]    start_ff, start_in;
   logic [stt_pkg::FIELD_BITS-1:0]    length_ff, length_in;
   logic [1:0]                        class_ff;
   logic                              last_ff;
   logic                              ovf_ff, ovf_in;

   logic [stt_pkg::CMP_W-1:0]         s_w, e_w, len_w;

   assign pop = head_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      s_w   = stt_pkg::CMP_W'(head.start);
      e_w   = stt_pkg::CMP_W'(head.stop);
      len_w = (e_w > s_w) ? e_w - s_w : stt_pkg::CMP_W'(1);
      ovf_in = head.ovf;
      if (len_w > POS_MAX_W) begin
         len_w  = POS_MAX_W;
         ovf_in = 1'b1;
      end
      if (len_w > FIELD_MAX_W) begin
         len_w  = FIELD_MAX_W;
         ovf_in = 1'b1;
      end
      length_in = len_w[stt_pkg::FIELD_BITS-1:0];
      if (s_w > FIELD_MAX_W) begin
         start_in = '1;
         ovf_in   = 1'b1;
      end else begin
         start_in = s_w[stt_pkg::FIELD_BITS-1:0];
      end
      valid_in = pop || (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         start_ff  <= start_in;
         length_ff <= length_in;
         class_ff  <= head.cls;
         last_ff   <= head.last;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.token_start    = start_ff;
   assign rsp_chan.token_length   = length_ff;
   assign rsp_chan.token_class    = class_ff;
   assign rsp_chan.last_of_run    = last_ff;
   assign rsp_chan.range_overflow = ovf_ff;

endmodule

// ===== rtl/source_text_tokenizer_unit.sv =====
// top level of the source text tokenizer: scanner, token queue and output stage
//
// channel    dir  payload                                              beat
// req_chan   in   text_byte, end_of_text                               one text byte
// rsp_chan   out  token_start, token_length, token_class,              one token
//                 last_of_run, range_overflow
//
// one byte is taken per cycle while the four-entry token queue has room for two tokens
// a token passes through a queue slot and then the output register before it reaches rsp_chan
// a byte that ends one token and is itself punctuation or flushes another token gives two beats
// synchronous reset clears scan state, queue pointers and the output valid
// a stalled output fills the queue; req_chan.ready drops once it holds more than two tokens
`timescale 1ns / 1ps

module source_text_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_chan,
   stt_rsp_if.source  rsp_chan
);

   stt_pkg::push_type  push;
   stt_pkg::token_type head;
   logic               has_room;
   logic               head_valid;
   logic               pop;
   logic               accept;

   assign req_chan.ready = has_room;
   assign accept         = req_chan.valid && has_room;

   stt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_chan.text_byte),
      .end_of_text (req_chan.end_of_text),
      .push        (push)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .has_room   (has_room),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
